/* rtl/suv_pkg.sv */
package suv_pkg;

    // Byte classification masks and tags
    localparam logic [7:0] LeadMask2    = 8'hE0;
    localparam logic [7:0] LeadTag2     = 8'hC0;
    localparam logic [7:0] LeadMask3    = 8'hF0;
    localparam logic [7:0] LeadTag3     = 8'hE0;
    localparam logic [7:0] LeadMask4    = 8'hF8;
    localparam logic [7:0] LeadTag4     = 8'hF0;
    localparam logic [7:0] ContMask     = 8'hC0;
    localparam logic [7:0] ContTag      = 8'h80;
    localparam logic [7:0] NulByte      = 8'h00;

    // Sequence lengths
    localparam logic [2:0] SeqLen2      = 3'd2;
    localparam logic [2:0] SeqLen3      = 3'd3;
    localparam logic [2:0] SeqLen4      = 3'd4;

    // Code point limits
    localparam logic [20:0] MinCp2      = 21'h000080;
    localparam logic [20:0] MinCp3      = 21'h000800;
    localparam logic [20:0] MinCp4      = 21'h010000;
    localparam logic [20:0] MaxCp       = 21'h10FFFF;
    localparam logic [20:0] SurrLow     = 21'h00D800;
    localparam logic [20:0] SurrHigh    = 21'h00DFFF;

    typedef struct packed {
        logic [1:0]  pending;
        logic [2:0]  seq_len;
        logic [20:0] code_point;
        logic        err;
    } suv_state_t;

    typedef struct packed {
        logic error_so_far;
        logic string_valid;
        logic string_end;
    } suv_result_t;

endpackage

/* rtl/suv_step.sv */
module suv_step
    import suv_pkg::*;
(
    input  suv_state_t  cur_state,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output suv_state_t  nxt_state,
    output suv_result_t result
);

    logic [20:0] cp_acc;
    logic [1:0]  pend_dec;
    logic        bad_cp;

    assign cp_acc   = {cur_state.code_point[14:0], data_byte[5:0]};
    assign pend_dec = cur_state.pending - 2'd1;

    always_comb begin
        bad_cp = ((cur_state.seq_len == SeqLen2) && (cp_acc < MinCp2)) ||
                 ((cur_state.seq_len == SeqLen3) && (cp_acc < MinCp3)) ||
                 ((cur_state.seq_len == SeqLen4) && (cp_acc < MinCp4)) ||
                 (cp_acc > MaxCp) ||
                 ((cp_acc >= SurrLow) && (cp_acc <= SurrHigh));
    end

    always_comb begin
        nxt_state = cur_state;
        if (!cur_state.err) begin
            if (cur_state.pending == 2'd0) begin
                if (!data_byte[7]) begin
                    if (data_byte == NulByte) begin
                        nxt_state = '0;
                        nxt_state.err = 1'b1;
                    end
                end else if ((data_byte & LeadMask2) == LeadTag2) begin
                    nxt_state.seq_len    = SeqLen2;
                    nxt_state.code_point = {16'd0, data_byte[4:0]};
                    nxt_state.pending    = 2'd1;
                end else if ((data_byte & LeadMask3) == LeadTag3) begin
                    nxt_state.seq_len    = SeqLen3;
                    nxt_state.code_point = {17'd0, data_byte[3:0]};
                    nxt_state.pending    = 2'd2;
                end else if ((data_byte & LeadMask4) == LeadTag4) begin
                    nxt_state.seq_len    = SeqLen4;
                    nxt_state.code_point = {18'd0, data_byte[2:0]};
                    nxt_state.pending    = 2'd3;
                end else begin
                    nxt_state = '0;
                    nxt_state.err = 1'b1;
                end
            end else if ((data_byte & ContMask) != ContTag) begin
                nxt_state = '0;
                nxt_state.err = 1'b1;
            end else if (pend_dec != 2'd0) begin
                nxt_state.code_point = cp_acc;
                nxt_state.pending    = pend_dec;
            end else begin
                // sequence complete: drop it, flag if overlong, out of range or a surrogate
                nxt_state = '0;
                nxt_state.err = bad_cp;
            end
        end

        result.error_so_far = nxt_state.err;
        result.string_valid = is_last && !nxt_state.err && (nxt_state.pending == 2'd0);
        result.string_end   = is_last;

        if (is_last) begin
            nxt_state = '0;
        end
    end

endmodule

/* rtl/strict_utf8_validator.sv */
// Channel  | Ports                                        | Fields, lowest bit up
// ---------+----------------------------------------------+--------------------------------
// s_ (in)  | s_tvalid s_tready s_tdata s_tlast            | data_byte; tlast = is_last
// m_ (out) | m_tvalid m_tready m_tdata m_tlast            | error_so_far, string_valid; tlast = string_end
//
// One byte per clock sustained while m_ accepts. A byte accepted on s_ is held in the
// input register, passes decode and is written to the result register for its m_ transaction.
// Reset (aresetn low, synchronous) empties both stages and clears the decoder state.
// A stall on m_ holds the result register; the input register keeps taking a byte
// while it is empty or while its byte moves into the result register.
module strict_utf8_validator
    import suv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,    // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [0] error_so_far, [1] string_valid, [7:2] zero
    output logic       m_tlast     // string_end
);

    // Input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Decoder state
    suv_state_t  state_reg;
    suv_state_t  state_next;

    // Result register
    logic        out_valid_reg;
    logic        out_valid_next;
    suv_result_t out_res_reg;
    suv_result_t step_res;

    logic        s_fire;
    logic        advance;

    // Move the held byte through decode when the result register frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    suv_step u_step (
        .cur_state (state_reg),
        .data_byte (in_byte_reg),
        .is_last   (in_last_reg),
        .nxt_state (state_next),
        .result    (step_res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload: capture on transaction, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.string_valid, out_res_reg.error_so_far};
    assign m_tlast  = out_res_reg.string_end;

    // A verdict of valid only on a clean final byte
    a_valid_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!out_res_reg.string_valid ||
                      (out_res_reg.string_end && !out_res_reg.error_so_far)))
        else $error("string_valid without clean string end");

    // Decoder state is cleared after the last byte of a string
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (state_reg == '0))
        else $error("decoder state not cleared after last byte");

    // Once an error is latched, the open sequence is dropped
    a_err_drops_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.err |-> (state_reg.pending == 2'd0 && state_reg.code_point == '0))
        else $error("sequence still open while error is latched");

    // Decoder state only moves when a byte passes decode
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(advance) |-> $stable(state_reg))
        else $error("decoder state changed without a byte");

endmodule

/* bench/tb_top.sv */
module tb_top;
    import suv_pkg::*;

    // Hard ceiling on the run; the slowest legal run is far below this.
    localparam int CycleLimit   = 200000;
    localparam int RandomBytes  = 1800;
    localparam int IdlePct      = 27;
    localparam int DirectedRows = 28;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] data_byte
    logic       s_tlast;    // is_last
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [0] error_so_far, [1] string_valid, [7:2] zero
    logic       m_tlast;    // string_end

    strict_utf8_validator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // One row of the directed table: the byte, its last flag, and, where the
    // answer is obvious, the result typed in by hand.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        suv_result_t want;
    } dir_row_t;

    dir_row_t    dir_rows [0:DirectedRows-1];
    suv_result_t decoder_results_q [$];
    logic [7:0]  utf8_bytes_q [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int tx_count       = 0;

    // Shadow copy of the decoder state.
    logic [1:0]  cont_left;
    logic [2:0]  seq_len;
    logic [20:0] cp_acc;
    logic        err_sticky;

    function automatic void drop_sequence();
        cont_left = '0;
        seq_len   = '0;
        cp_acc    = '0;
    endfunction

    function automatic void flag_error();
        err_sticky = 1'b1;
        drop_sequence();
    endfunction

    // Advance the shadow decoder by one byte and return the result it owes.
    function automatic suv_result_t decode_byte(input logic [7:0] b, input logic last);
        suv_result_t r;
        logic [20:0] cp;
        if (!err_sticky) begin
            if (cont_left == 2'd0) begin
                // Lead position: ASCII, one of the three lead forms, or junk.
                if (!b[7]) begin
                    if (b == NulByte)
                        flag_error();
                end else if ((b & LeadMask2) == LeadTag2) begin
                    seq_len   = SeqLen2;
                    cp_acc    = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end else if ((b & LeadMask3) == LeadTag3) begin
                    seq_len   = SeqLen3;
                    cp_acc    = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end else if ((b & LeadMask4) == LeadTag4) begin
                    seq_len   = SeqLen4;
                    cp_acc    = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end else begin
                    flag_error();
                end
            end else if ((b & ContMask) != ContTag) begin
                flag_error();
            end else begin
                cp        = {cp_acc[14:0], b[5:0]};
                cp_acc    = cp;
                cont_left = cont_left - 2'd1;
                // Sequence complete: reject overlong, out-of-range and surrogates.
                if (cont_left == 2'd0) begin
                    if ((seq_len == SeqLen2 && cp < MinCp2) ||
                        (seq_len == SeqLen3 && cp < MinCp3) ||
                        (seq_len == SeqLen4 && cp < MinCp4) ||
                        cp > MaxCp || (cp >= SurrLow && cp <= SurrHigh))
                        flag_error();
                    else
                        drop_sequence();
                end
            end
        end
        r.error_so_far = err_sticky;
        r.string_valid = last && !err_sticky && (cont_left == 2'd0);
        r.string_end   = last;
        if (last) begin
            drop_sequence();
            err_sticky = 1'b0;
        end
        return r;
    endfunction

    // Encode a code point in n bytes, whether or not that form is legal.
    function automatic void push_char(input logic [20:0] cp, input int n);
        case (n)
            1: utf8_bytes_q.push_back({1'b0, cp[6:0]});
            2: begin
                utf8_bytes_q.push_back(LeadTag2 | {3'd0, cp[10:6]});
                utf8_bytes_q.push_back(ContTag | {2'd0, cp[5:0]});
            end
            3: begin
                utf8_bytes_q.push_back(LeadTag3 | {4'd0, cp[15:12]});
                utf8_bytes_q.push_back(ContTag | {2'd0, cp[11:6]});
                utf8_bytes_q.push_back(ContTag | {2'd0, cp[5:0]});
            end
            default: begin
                utf8_bytes_q.push_back(LeadTag4 | {5'd0, cp[20:18]});
                utf8_bytes_q.push_back(ContTag | {2'd0, cp[17:12]});
                utf8_bytes_q.push_back(ContTag | {2'd0, cp[11:6]});
                utf8_bytes_q.push_back(ContTag | {2'd0, cp[5:0]});
            end
        endcase
    endfunction

    // Pick a legal code point that needs exactly n bytes.
    function automatic logic [20:0] legal_cp(input int n);
        logic [20:0] cp;
        case (n)
            1: cp = 21'($urandom_range(1, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: begin
                // Skip over the surrogate block.
                cp = 21'($urandom_range('h800, 'hF7FF));
                if (cp >= SurrLow)
                    cp = cp + 21'h800;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // Offer one byte and hold it until the transaction completes. Enter and
    // leave on a falling edge; s_tvalid gets one assignment per edge.
    task automatic offer_byte(input logic [7:0] b, input logic last,
                              input logic typed, input suv_result_t want);
        suv_result_t predicted;
        // Random gaps, except for one long steady stretch of the stream.
        while (!(tx_count >= 900 && tx_count < 1300) &&
               $urandom_range(0, 99) < IdlePct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predicted = decode_byte(b, last);
        decoder_results_q.push_back(typed ? want : predicted);
        tx_count++;
        @(negedge aclk);
    endtask

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random backpressure, one long hold-off so the pipeline fills
    // and pushes back on the sender, and one stretch of steady acceptance.
    initial begin : receiver
        int rx_cycle;
        rx_cycle = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (rx_cycle >= 1500 && rx_cycle < 1700)
                m_tready <= 1'b0;
            else if (rx_cycle >= 600 && rx_cycle < 1100)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= IdlePct);
        end
    end

    // Compare every result transaction with the oldest prediction.
    always @(posedge aclk) begin
        suv_result_t want;
        suv_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{error_so_far: m_tdata[0], string_valid: m_tdata[1], string_end: m_tlast};
            if (decoder_results_q.size() == 0) begin
                $display("%0t: unexpected result, actual err=%0b valid=%0b end=%0b",
                         $time, got.error_so_far, got.string_valid, got.string_end);
                mismatch_count++;
            end else begin
                want = decoder_results_q.pop_front();
                if (got !== want || m_tdata[7:2] !== 6'd0) begin
                    $display("%0t: mismatch, expected err=%0b valid=%0b end=%0b pad=00, %s",
                             $time, want.error_so_far, want.string_valid, want.string_end,
                             "see actual below");
                    $display("%0t:           actual err=%0b valid=%0b end=%0b pad=%0h",
                             $time, got.error_so_far, got.string_valid, got.string_end,
                             m_tdata[7:2]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int   kind;
        int   n;
        int   chars;
        int   drop;
        logic [20:0] cp;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        drop_sequence();
        err_sticky = 1'b0;

        // Hand-checked cases first: typed results where the answer is plain,
        // the rest go through the shadow decoder.
        dir_rows = '{
            // plain ASCII string right after reset
            '{8'h41, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1}},
            // NUL byte
            '{8'h00, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1}},
            // stray continuation in lead position
            '{8'h80, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1}},
            // all-ones byte is never a lead
            '{8'hFF, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1}},
            // sequence still open at the last byte: invalid without an error
            '{8'hC2, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1}},
            // overlong two-byte form
            '{8'hC0, 1'b0, 1'b0, 3'b000},
            '{8'h80, 1'b1, 1'b0, 3'b000},
            // overlong three-byte form
            '{8'hE0, 1'b0, 1'b0, 3'b000},
            '{8'h80, 1'b0, 1'b0, 3'b000},
            '{8'h80, 1'b1, 1'b0, 3'b000},
            // surrogate
            '{8'hED, 1'b0, 1'b0, 3'b000},
            '{8'hA0, 1'b0, 1'b0, 3'b000},
            '{8'h80, 1'b1, 1'b0, 3'b000},
            // just above the top code point
            '{8'hF4, 1'b0, 1'b0, 3'b000},
            '{8'h90, 1'b0, 1'b0, 3'b000},
            '{8'h80, 1'b0, 1'b0, 3'b000},
            '{8'h80, 1'b1, 1'b0, 3'b000},
            // F5 lead accepted, rejected only once complete
            '{8'hF5, 1'b0, 1'b0, 3'b000},
            '{8'h80, 1'b0, 1'b0, 3'b000},
            '{8'h80, 1'b0, 1'b0, 3'b000},
            '{8'h80, 1'b1, 1'b0, 3'b000},
            // top code point, valid
            '{8'hF4, 1'b0, 1'b0, 3'b000},
            '{8'h8F, 1'b0, 1'b0, 3'b000},
            '{8'hBF, 1'b0, 1'b0, 3'b000},
            '{8'hBF, 1'b1, 1'b0, 3'b000},
            // bad continuation, then a NUL that must be ignored after the error
            '{8'hC3, 1'b0, 1'b0, 3'b000},
            '{8'h41, 1'b0, 1'b0, 3'b000},
            '{8'h00, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1}}
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DirectedRows; i++)
            offer_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                       dir_rows[i].want);

        // Random strings: mostly well-formed characters with random content,
        // mixed with illegal encodings, truncated sequences and raw noise.
        while (tx_count < DirectedRows + RandomBytes) begin
            utf8_bytes_q.delete();
            chars = $urandom_range(1, 6);
            for (int c = 0; c < chars; c++) begin
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    n = $urandom_range(1, 4);
                    push_char(legal_cp(n), n);
                end else if (kind < 80) begin
                    // any 21-bit value in any length: overlong, surrogate, too big
                    n  = $urandom_range(1, 4);
                    cp = 21'($urandom);
                    push_char(cp, n);
                end else if (kind < 90) begin
                    // cut a legal sequence short
                    n = $urandom_range(2, 4);
                    push_char(legal_cp(n), n);
                    drop = $urandom_range(1, n - 1);
                    repeat (drop) void'(utf8_bytes_q.pop_back());
                end else begin
                    utf8_bytes_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            foreach (utf8_bytes_q[j])
                offer_byte(utf8_bytes_q[j], j == utf8_bytes_q.size() - 1, 1'b0, 3'b000);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the two pipeline stages to settle.
        while (decoder_results_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (decoder_results_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, decoder_results_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/suv_pkg.sv
rtl/suv_step.sv
rtl/strict_utf8_validator.sv
bench/tb_top.sv
